>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/sbf_pkg.sv
`timescale 1ns / 1ps
package sbf_pkg;
  localparam int unsigned SCREEN_WIDTH_DEF  = 320;
  localparam int unsigned SCREEN_HEIGHT_DEF = 240;
  localparam int unsigned PALETTE_SIZE_DEF  = 16;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned POSX_W   = 10;
  localparam int unsigned POSY_W   = 9;
  localparam int unsigned PIX_W    = 4;
  localparam int unsigned RGB_W    = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 9;
  localparam logic [1:0] CMD_DRAW  = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_PAL   = 2'd3;
  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_FLIPH  = 3'd2;
  localparam logic [2:0] REG_FLIPV  = 3'd3;
  localparam logic [2:0] REG_BG     = 3'd4;

  typedef struct packed {
    logic start;
    logic clear_step;
    logic rmw_write;
    logic finish;
  } sbf_cmd_t;

  typedef struct packed {
    logic clear_last;
  } sbf_stat_t;

  function automatic logic [23:0] init_palette(input logic [3:0] i);
    logic [23:0] c;
    case (i)
      4'd0: c = 24'h000000;  4'd1: c = 24'h000000;
      4'd2: c = 24'h888888;  4'd3: c = 24'h3239BF;
      4'd4: c = 24'hAE7ADE;  4'd5: c = 24'h213D4C;
      4'd6: c = 24'h255F90;  4'd7: c = 24'h5294E4;
      4'd8: c = 24'h79D9EA;  4'd9: c = 24'h3B7A53;
      4'd10: c = 24'h4AD5AB; 4'd11: c = 24'h382E25;
      4'd12: c = 24'h7F4600; 4'd13: c = 24'hCCAB68;
      4'd14: c = 24'hE4DEBC; default: c = 24'hFFFFFF;
    endcase
    return c;
  endfunction
endpackage

>>> rtl/sprite_blit_framebuffer.sv
`timescale 1ns / 1ps
// Sprite blitter over a 4-bit indexed framebuffer with a 16-entry palette.
// Each request is accepted with the registered framebuffer read, then written
// back with the result, so a new request is taken only once the last one is
// through; a result still waiting holds off the next request.
// Clear and the sweep after reset run one framebuffer entry per cycle over all
// SCREEN_WIDTH*SCREEN_HEIGHT entries (76800 by default), with no request taken.
module sprite_blit_framebuffer #(
  parameter int unsigned SCREEN_WIDTH  = sbf_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = sbf_pkg::SCREEN_HEIGHT_DEF,
  parameter int unsigned PALETTE_SIZE  = sbf_pkg::PALETTE_SIZE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pos_x[9:0], pos_y[18:10], pixel_value[22:19], rgb_value[46:23]
  input  logic [47:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,  // cmd
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // colour[23:0], hit[24], done_res[25]
  output logic [31:0] m_axis_tdata
);
  import sbf_pkg::*;

  sbf_cmd_t  cmd;
  sbf_stat_t stat;
  logic res_busy;
  logic [23:0] colour;
  logic hit, done_res;

  assign cfg_ready_o = 1'b1;

  sbf_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(s_axis_tvalid),
    .in_cmd_i(s_axis_tuser), .res_busy_i(res_busy), .stat_i(stat),
    .in_ready_o(s_axis_tready), .cmd_o(cmd)
  );

  sbf_datapath #(
    .SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .PALETTE_SIZE(PALETTE_SIZE)
  ) u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd), .stat_o(stat),
    .cfg_valid_i(cfg_valid_i), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .in_cmd_i(s_axis_tuser), .in_pos_x_i(s_axis_tdata[9:0]),
    .in_pos_y_i(s_axis_tdata[18:10]), .in_pixel_i(s_axis_tdata[22:19]),
    .in_last_i(s_axis_tlast), .in_rgb_i(s_axis_tdata[46:23]),
    .res_busy_o(res_busy), .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_colour_o(colour), .out_hit_o(hit), .out_done_o(done_res)
  );

  assign m_axis_tdata = {6'd0, done_res, hit, colour};
endmodule

>>> rtl/sbf_ram.sv
`timescale 1ns / 1ps
module sbf_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 76800
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

>>> rtl/sbf_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sbf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [1:0]         in_cmd_i,
  input  logic               res_busy_i,
  input  sbf_pkg::sbf_stat_t stat_i,
  output logic               in_ready_o,
  output sbf_pkg::sbf_cmd_t  cmd_o
);
  import sbf_pkg::*;

  typedef enum logic [1:0] {S_INIT, S_IDLE, S_CLEAR, S_WORK} state_e;
  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE) && !res_busy_i;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      S_INIT: begin
        cmd_o.clear_step = 1'b1;
        if (stat_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.start = 1'b1;
          state_d = (in_cmd_i == CMD_CLEAR) ? S_CLEAR : S_WORK;
        end
      end
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (stat_i.clear_last) begin
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_WORK: begin
        cmd_o.rmw_write = 1'b1;
        cmd_o.finish = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_INIT;
    else state_q <= state_d;
  end

  `ASSERT_IMPL(a_ready_idle, in_ready_o, state_q == S_IDLE)
  `ASSERT_NEXT(a_start_leaves, cmd_o.start, state_q != S_IDLE)
  `ASSERT_IMPL(a_one_op, cmd_o.start, !cmd_o.clear_step && !cmd_o.finish)
endmodule

>>> rtl/sbf_datapath.sv
`timescale 1ns / 1ps
module sbf_datapath #(
  parameter int unsigned SCREEN_WIDTH  = sbf_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = sbf_pkg::SCREEN_HEIGHT_DEF,
  parameter int unsigned PALETTE_SIZE  = sbf_pkg::PALETTE_SIZE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sbf_pkg::sbf_cmd_t  cmd_i,
  output sbf_pkg::sbf_stat_t stat_o,
  input  logic               cfg_valid_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [8:0]         cfg_data_i,
  input  logic [1:0]         in_cmd_i,
  input  logic signed [9:0]  in_pos_x_i,
  input  logic signed [8:0]  in_pos_y_i,
  input  logic [3:0]         in_pixel_i,
  input  logic               in_last_i,
  input  logic [23:0]        in_rgb_i,
  output logic               res_busy_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [23:0]        out_colour_o,
  output logic               out_hit_o,
  output logic               out_done_o
);
  import sbf_pkg::*;

  localparam int unsigned DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int unsigned AW = $clog2(DEPTH);

  logic [8:0] width_q;
  logic [7:0] height_q;
  logic       fliph_q, flipv_q;
  logic [3:0] bg_q;
  logic [23:0] pal_q [PALETTE_SIZE];
  logic [7:0] row_q;
  logic [8:0] col_q;
  logic       hit_seen_q, rej_q;
  logic [AW-1:0] clr_addr_q;

  logic [1:0]  op_q;
  logic [3:0]  pix_q;
  logic        last_q, act_q;
  logic [AW-1:0] addr_q;
  logic [23:0] out_colour_q;
  logic        out_hit_q, out_done_q, out_valid_q;

  // address calculation on accept
  logic signed [11:0] ox, oy, tx, ty;
  logic in_range, active, onscr;
  logic [AW-1:0] addr_c;
  always_comb begin
    ox = fliph_q ? ($signed({3'b0, width_q}) - 12'sd1 - $signed({3'b0, col_q}))
                 : $signed({3'b0, col_q});
    oy = flipv_q ? ($signed({4'b0, height_q}) - 12'sd1 - $signed({4'b0, row_q}))
                 : $signed({4'b0, row_q});
    in_range = (in_pos_x_i >= -10'sd1)
            && ($signed({{2{in_pos_x_i[9]}}, in_pos_x_i}) < $signed(12'(SCREEN_WIDTH)))
            && (in_pos_y_i >= -9'sd1)
            && ($signed({{3{in_pos_y_i[8]}}, in_pos_y_i}) < $signed(12'(SCREEN_HEIGHT)));
    if (in_cmd_i == CMD_DRAW) begin
      tx = $signed({{2{in_pos_x_i[9]}}, in_pos_x_i}) + ox;
      ty = $signed({{3{in_pos_y_i[8]}}, in_pos_y_i}) + oy;
    end else begin
      tx = $signed({{2{in_pos_x_i[9]}}, in_pos_x_i});
      ty = $signed({{3{in_pos_y_i[8]}}, in_pos_y_i});
    end
    onscr = (tx >= 0) && (tx < $signed(12'(SCREEN_WIDTH)))
         && (ty >= 0) && (ty < $signed(12'(SCREEN_HEIGHT)));
    active = in_range && !rej_q && (row_q < height_q) && (col_q < width_q) && onscr;
    addr_c = AW'(ty[10:0] * SCREEN_WIDTH + tx[10:0]);
  end

  logic [3:0] fb_rdata;
  logic       fb_we;
  logic [AW-1:0] fb_waddr;
  logic [3:0] fb_wdata;
  assign fb_we = cmd_i.clear_step || (cmd_i.rmw_write && op_q == CMD_DRAW && act_q
                                      && pix_q != 4'd0);
  assign fb_waddr = cmd_i.clear_step ? clr_addr_q : addr_q;
  assign fb_wdata = cmd_i.clear_step ? 4'd0 : pix_q;

  sbf_ram #(.WIDTH(4), .DEPTH(DEPTH)) u_fb (
    .clk_i(clk_i), .we_i(fb_we), .waddr_i(fb_waddr), .wdata_i(fb_wdata),
    .raddr_i(addr_c), .rdata_o(fb_rdata)
  );

  assign stat_o.clear_last = (clr_addr_q == AW'(DEPTH - 1));
  assign res_busy_o = out_valid_q && !out_ready_i;

  logic [8:0] col_inc;
  logic       seen_now;
  logic [23:0] read_colour;
  assign col_inc = col_q + 9'd1;
  assign seen_now = act_q && fb_rdata != 4'd0;
  assign read_colour = (fb_rdata != 4'd0) ? pal_q[fb_rdata] : pal_q[bg_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= '0; height_q <= '0; fliph_q <= 1'b0; flipv_q <= 1'b0; bg_q <= '0;
      row_q <= '0; col_q <= '0; hit_seen_q <= 1'b0; rej_q <= 1'b0;
      clr_addr_q <= '0; out_valid_q <= 1'b0; act_q <= 1'b0;
      op_q <= CMD_DRAW; pix_q <= '0; last_q <= 1'b0; addr_q <= '0;
      out_colour_q <= '0; out_hit_q <= 1'b0; out_done_q <= 1'b0;
      for (int i = 0; i < PALETTE_SIZE; i++) pal_q[i] <= init_palette(4'(i));
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_WIDTH:  width_q <= cfg_data_i;
          REG_HEIGHT: height_q <= cfg_data_i[7:0];
          REG_FLIPH:  fliph_q <= cfg_data_i[0];
          REG_FLIPV:  flipv_q <= cfg_data_i[0];
          REG_BG:     bg_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (cmd_i.clear_step)
        clr_addr_q <= stat_o.clear_last ? '0 : clr_addr_q + AW'(1);
      if (cmd_i.start) begin
        op_q <= in_cmd_i; pix_q <= in_pixel_i; last_q <= in_last_i;
        addr_q <= addr_c;
        act_q <= (in_cmd_i == CMD_DRAW) ? active : onscr;
        if (in_cmd_i == CMD_DRAW) begin
          if (!in_range) rej_q <= 1'b1;
          if (col_inc >= width_q) begin
            col_q <= '0; row_q <= row_q + 8'd1;
          end else col_q <= col_inc;
        end
        if (in_cmd_i == CMD_PAL) pal_q[in_pixel_i] <= in_rgb_i;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
        out_colour_q <= (op_q == CMD_READ && act_q) ? read_colour : '0;
        out_hit_q <= (op_q == CMD_DRAW) && last_q && (hit_seen_q || seen_now) && !rej_q;
        out_done_q <= !((op_q == CMD_DRAW) && !last_q);
        if (op_q == CMD_DRAW) begin
          if (last_q) begin
            row_q <= '0; col_q <= '0; hit_seen_q <= 1'b0; rej_q <= 1'b0;
          end else if (seen_now) hit_seen_q <= 1'b1;
        end
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_colour_o = out_colour_q;
  assign out_hit_o = out_hit_q;
  assign out_done_o = out_done_q;
endmodule

>>> verif/sprite_blit_framebuffer_tb.sv
`timescale 1ns / 1ps
module sprite_blit_framebuffer_tb;
  import sbf_pkg::*;

  localparam int SCR_W = 320;
  localparam int SCR_H = 240;
  localparam int WATCHDOG_LIMIT = 250000;

  typedef struct packed {
    logic [1:0]        cmd;
    logic signed [9:0] px;
    logic signed [8:0] py;
    logic [3:0]        pix;
    logic              last;
    logic [23:0]       rgb;
  } blit_req_t;

  typedef struct packed {
    logic [23:0] colour;
    logic        hit;
    logic        done;
  } blit_rsp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [8:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  sprite_blit_framebuffer uut (.*);

  always #10 clk_i = ~clk_i;

  blit_req_t pending_reqs[$];
  blit_rsp_t expected_rsps[$];
  blit_req_t shown_req = '0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int stall_req = 0;
  int stall_seen = 0;
  int stall_cnt = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int random_items = 0;

  // shadow of the block
  logic [3:0]  fb_shadow[SCR_W*SCR_H];
  logic [23:0] pal_shadow[16];
  int spr_w, spr_h, flip_h, flip_v, bg_idx;
  int row_cnt, col_cnt;
  bit hit_flag, rejected;

  function automatic void reset_shadow();
    logic [23:0] init_pal[16] = '{24'h000000, 24'h000000, 24'h888888, 24'h3239BF,
                                  24'hAE7ADE, 24'h213D4C, 24'h255F90, 24'h5294E4,
                                  24'h79D9EA, 24'h3B7A53, 24'h4AD5AB, 24'h382E25,
                                  24'h7F4600, 24'hCCAB68, 24'hE4DEBC, 24'hFFFFFF};
    foreach (fb_shadow[i]) fb_shadow[i] = '0;
    foreach (pal_shadow[i]) pal_shadow[i] = init_pal[i];
    spr_w = 0; spr_h = 0; flip_h = 0; flip_v = 0; bg_idx = 0;
    row_cnt = 0; col_cnt = 0; hit_flag = 0; rejected = 0;
  endfunction

  function automatic blit_rsp_t blit_predict(blit_req_t r);
    blit_rsp_t e;
    int px, py, ox, oy, x, y;
    px = r.px;
    py = r.py;
    e = '{colour: '0, hit: 1'b0, done: 1'b1};
    case (r.cmd)
      CMD_DRAW: begin
        if (px < -1 || px > SCR_W - 1 || py < -1 || py > SCR_H - 1) rejected = 1;
        if (!rejected && row_cnt < spr_h && col_cnt < spr_w) begin
          ox = flip_h ? spr_w - 1 - col_cnt : col_cnt;
          oy = flip_v ? spr_h - 1 - row_cnt : row_cnt;
          x = px + ox;
          y = py + oy;
          if (x >= 0 && x < SCR_W && y >= 0 && y < SCR_H) begin
            if (fb_shadow[y*SCR_W + x] != 0) hit_flag = 1;
            if (r.pix != 0) fb_shadow[y*SCR_W + x] = r.pix;
          end
        end
        col_cnt = (col_cnt + 1) & 511;
        if (col_cnt >= spr_w) begin
          col_cnt = 0;
          row_cnt = (row_cnt + 1) & 255;
        end
        if (r.last) begin
          e.hit = hit_flag && !rejected;
          row_cnt = 0; col_cnt = 0; hit_flag = 0; rejected = 0;
        end else begin
          e.done = 1'b0;
        end
      end
      CMD_CLEAR: foreach (fb_shadow[i]) fb_shadow[i] = '0;
      CMD_READ: begin
        if (px >= 0 && px < SCR_W && py >= 0 && py < SCR_H) begin
          if (fb_shadow[py*SCR_W + px] != 0) e.colour = pal_shadow[fb_shadow[py*SCR_W + px]];
          else e.colour = pal_shadow[bg_idx];
        end
      end
      default: pal_shadow[r.pix] = r.rgb;
    endcase
    return e;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        shown_req <= pending_reqs[0];
        s_axis_tdata <= {1'b0, pending_reqs[0].rgb, pending_reqs[0].pix,
                         pending_reqs[0].py, pending_reqs[0].px};
        s_axis_tuser <= pending_reqs[0].cmd;
        s_axis_tlast <= pending_reqs[0].last;
        s_axis_tvalid <= 1'b1;
        void'(pending_reqs.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk_i) begin
    if (stall_seen != stall_req) begin
      stall_seen <= stall_req;
      stall_cnt <= 400;
      m_axis_tready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // monitors and watchdog
  always @(posedge clk_i) begin
    blit_rsp_t got, want;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (cfg_valid_i && cfg_ready_o)
          || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (s_axis_tvalid && s_axis_tready)
        expected_rsps.push_back(blit_predict(shown_req));
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{colour: m_axis_tdata[23:0], hit: m_axis_tdata[24], done: m_axis_tdata[25]};
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
        end else begin
          want = expected_rsps.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: colour %h/%h hit %b/%b done %b/%b (expected/actual)",
                       want.colour, got.colour, want.hit, got.hit, want.done, got.done);
          end
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic cfg_write(logic [2:0] idx, int data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data[8:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_WIDTH:  spr_w = data & 511;
      REG_HEIGHT: spr_h = data & 255;
      REG_FLIPH:  flip_h = data & 1;
      REG_FLIPV:  flip_v = data & 1;
      default:    bg_idx = data & 15;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_sprite_regs(int w, int h, int fh, int fv, int bg);
    cfg_write(REG_WIDTH, w);
    cfg_write(REG_HEIGHT, h);
    cfg_write(REG_FLIPH, fh);
    cfg_write(REG_FLIPV, fv);
    cfg_write(REG_BG, bg);
  endtask

  task automatic add_req(logic [1:0] cmd, int px, int py, int pix, bit last, int rgb);
    blit_req_t r;
    r.cmd = cmd;
    r.px = px[9:0];
    r.py = py[8:0];
    r.pix = pix[3:0];
    r.last = last;
    r.rgb = rgb[23:0];
    pending_reqs.push_back(r);
    random_items++;
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || s_axis_tvalid || expected_rsps.size() > 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic add_sprite(int n, int px, int py);
    for (int i = 0; i < n; i++)
      add_req(CMD_DRAW, px, py, ($urandom_range(9) < 3) ? 0 : $urandom_range(15),
              i == n - 1, $urandom());
  endtask

  initial begin
    int w, h, n, px, py;
    reset_shadow();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // corner cases
    set_sprite_regs(2, 2, 0, 0, 15);
    add_req(CMD_PAL, 0, 0, 15, 0, 24'hFFFFFF);
    add_req(CMD_PAL, 0, 0, 0, 0, 24'h000000);
    add_req(CMD_READ, -1, -1, 0, 0, 0);
    add_req(CMD_READ, 319, 239, 0, 1, 0);
    add_req(CMD_READ, 0, 0, 0, 0, 0);
    add_sprite(4, -1, -1);
    add_sprite(4, 318, 238);
    add_sprite(4, 318, 238);
    add_req(CMD_READ, 319, 239, 0, 0, 0);
    add_sprite(4, 320, 0);
    add_sprite(4, -512, -256);
    add_sprite(4, 511, 255);
    add_req(CMD_READ, 511, 255, 0, 0, 0);
    add_req(CMD_CLEAR, 0, 0, 0, 0, 0);
    add_req(CMD_READ, 319, 239, 0, 0, 0);
    drain();
    set_sprite_regs(510, 255, 1, 1, 0);
    add_sprite(20, 5, 5);
    drain();
    set_sprite_regs(0, 0, 0, 1, 4);
    add_sprite(3, 10, 10);
    add_req(CMD_READ, 10, 10, 0, 0, 0);
    drain();

    random_items = 0;
    for (int ph = 0; random_items < 950; ph++) begin
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
        1: begin tx_idle_pct = 66; rx_idle_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_idle_pct = 66; end
        default: begin tx_idle_pct = 26; rx_idle_pct = 26; end
      endcase
      w = ($urandom_range(19) == 0) ? 510 : ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 8);
      h = ($urandom_range(19) == 0) ? 255 : ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 6);
      set_sprite_regs(w, h, $urandom_range(1), $urandom_range(1), $urandom_range(15));
      if (ph == 5) stall_req++;
      for (int s = 0; s < $urandom_range(1, 3); s++) begin
        if ($urandom_range(9) == 0) begin
          px = $signed(10'($urandom()));
          py = $signed(9'($urandom()));
        end else begin
          px = $urandom_range(0, 320) - 1;
          py = $urandom_range(0, 240) - 1;
        end
        n = (w >= 510 || h >= 255 || w * h == 0) ? $urandom_range(3, 30) : w * h;
        if ($urandom_range(5) == 0) n = n + $urandom_range(0, 4) - 2;
        if (n < 1) n = 1;
        add_sprite(n, px, py);
        for (int k = 0; k < $urandom_range(2, 6); k++)
          add_req(CMD_READ, px + $urandom_range(0, 9) - 1, py + $urandom_range(0, 7) - 1,
                  $urandom(), $urandom(), $urandom());
        if ($urandom_range(3) == 0)
          add_req(CMD_PAL, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        if ($urandom_range(4) == 0)
          add_req(CMD_READ, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      end
      if (ph == 9 || ph == 21) add_req(CMD_CLEAR, $urandom(), $urandom(), 0, 0, 0);
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
